>>> design/bat_pkg.sv
// ----------------------------------------------------------------------------
// Bonded address table package
// Word types, command codes and the control word broadcast to the cells.
// ----------------------------------------------------------------------------
package bat_pkg;

	localparam int ADDR_W        = 48;
	localparam int CMD_W         = 3;
	localparam int CNT_W         = 4;
	localparam int MAX_BONDS_DEF = 10;

	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd3;
	localparam logic [CMD_W-1:0] CMD_LIST   = 3'd4;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [ADDR_W-1:0] peer_address;
	} req_t;

	typedef struct packed {
		logic              found;
		logic              evicted;
		logic [CNT_W-1:0]  entry_count;
		logic [ADDR_W-1:0] listed_address;
		logic              entry_valid;
		logic              last;
	} rsp_t;

	typedef struct packed {
		logic              clear;
		logic              rotate;
		logic              remove;
		logic              insert;
		logic              full;
		logic [ADDR_W-1:0] addr;
	} cell_ctrl_t;

endpackage

>>> design/bat_cell.sv
// ----------------------------------------------------------------------------
// Bonded address table cell
// One slot of the ordered table: compares, shifts from its younger neighbor,
// or takes a new address when it is the first free slot.
// ----------------------------------------------------------------------------
module bat_cell import bat_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctrl_t        ctrl,
	input  logic [ADDR_W-1:0] nxt_slot,
	input  logic              nxt_occ,
	input  logic              prev_occ,
	input  logic              shift_in,
	output logic [ADDR_W-1:0] slot,
	output logic              occ,
	output logic              match,
	output logic              shift_out
);

	logic [ADDR_W-1:0] slot_q;
	logic              occ_q;
	logic              take_nxt;
	logic              put_new;

	assign match     = occ_q && (slot_q == ctrl.addr);
	assign shift_out = shift_in | match;
	assign take_nxt  = ctrl.rotate | (ctrl.remove & shift_out) | (ctrl.insert & ctrl.full);
	assign put_new   = ctrl.insert & ~ctrl.full & ~occ_q & prev_occ;

	always_ff @(posedge clk) begin
		if (take_nxt) begin
			slot_q <= nxt_slot;
		end else if (put_new) begin
			slot_q <= ctrl.addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctrl.clear) begin
			occ_q <= 1'b0;
		end else if (take_nxt) begin
			occ_q <= nxt_occ;
		end else if (put_new) begin
			occ_q <= 1'b1;
		end
	end

	assign slot = slot_q;
	assign occ  = occ_q;

endmodule

>>> design/bonded_address_table.sv
// ----------------------------------------------------------------------------
// Bonded address table
// Ordered table of peer addresses, oldest first, kept in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command word (insert, remove, clear, lookup, list) with
//   a peer address; rsp carries result words. Both channels use valid/stall.
//   A command is taken only while the table is idle; one command is in work
//   at a time, and the next may be taken while the last result still waits.
//   Insert, remove, clear, lookup and unused codes: one result word, loaded
//   when the command executes (the command is registered at acceptance, and
//   all cells compare and update at once in the execute state, which waits
//   for a free output register); the next command is taken after that.
//   List: the cell row rotates one place per cycle while the output is not
//   stalled, through all MAX_BONDS cells, emitting cell 0 while it holds a
//   stored entry; the first entry word is loaded at the first rotation, and
//   the next command is taken once all cells have rotated.
//   An empty list gives one word with entry_valid low.
//   A stalled receiver holds the result word and freezes the rotation.
//   Reset empties the table and the output register; slot contents are not
//   cleared and are only read once written.
// ----------------------------------------------------------------------------
module bonded_address_table import bat_pkg::*; #(
	parameter int MAX_BONDS = MAX_BONDS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int CW = $clog2(MAX_BONDS + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_LIST = 3'b100
	} state_t;

	state_t            state_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_d;
	logic [CW-1:0]     idx_q;
	rsp_t              rsp_q;
	rsp_t              rsp_d;
	logic              rsp_valid_q;
	logic              out_free;
	logic              exec_go;
	logic              list_go;
	logic              load;
	logic              found;
	logic              full;
	logic [CW+3:0]     count_ext;
	cell_ctrl_t        ctrl;

	logic [ADDR_W-1:0] slot     [MAX_BONDS];
	logic [ADDR_W-1:0] nxt_slot [MAX_BONDS];
	logic              occ      [MAX_BONDS];
	logic              nxt_occ  [MAX_BONDS];
	logic              prev_occ [MAX_BONDS];
	logic              shift_in [MAX_BONDS];
	logic              shift_out[MAX_BONDS];
	logic [MAX_BONDS-1:0] match;

	assign out_free = ~rsp_valid_q | ~rsp_stall;
	assign exec_go  = (state_q == ST_EXEC) && out_free;
	assign list_go  = (state_q == ST_LIST) && out_free;
	assign found    = |match;
	assign full     = occ[MAX_BONDS-1];

	assign ctrl.clear  = exec_go && (cmd_q == CMD_CLEAR);
	assign ctrl.rotate = list_go;
	assign ctrl.remove = exec_go && (cmd_q == CMD_REMOVE) && found;
	assign ctrl.insert = exec_go && (cmd_q == CMD_INSERT) && !found;
	assign ctrl.full   = full;
	assign ctrl.addr   = addr_q;

	for (genvar i = 0; i < MAX_BONDS; i++) begin : g_cell
		if (i == MAX_BONDS - 1) begin : g_tail
			assign nxt_slot[i] = ctrl.rotate ? slot[0] : addr_q;
			assign nxt_occ[i]  = ctrl.rotate ? occ[0] : ctrl.insert;
		end else begin : g_body
			assign nxt_slot[i] = slot[i+1];
			assign nxt_occ[i]  = occ[i+1];
		end
		if (i == 0) begin : g_head
			assign prev_occ[i] = 1'b1;
			assign shift_in[i] = 1'b0;
		end else begin : g_link
			assign prev_occ[i] = occ[i-1];
			assign shift_in[i] = shift_out[i-1];
		end

		bat_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.nxt_slot (nxt_slot[i]),
			.nxt_occ  (nxt_occ[i]),
			.prev_occ (prev_occ[i]),
			.shift_in (shift_in[i]),
			.slot     (slot[i]),
			.occ      (occ[i]),
			.match    (match[i]),
			.shift_out(shift_out[i])
		);
	end

	always_comb begin
		count_d = count_q;
		if (ctrl.clear) begin
			count_d = '0;
		end else if (ctrl.insert && !full) begin
			count_d = count_q + CW'(1);
		end else if (ctrl.remove) begin
			count_d = count_q - CW'(1);
		end
	end

	assign count_ext = {4'b0000, count_d};

	always_comb begin
		rsp_d                = '0;
		rsp_d.entry_count    = count_ext[CNT_W-1:0];
		rsp_d.last           = 1'b1;
		load                 = 1'b0;
		if (exec_go) begin
			unique case (cmd_q)
				CMD_INSERT: begin
					rsp_d.found   = found;
					rsp_d.evicted = !found && full;
					load          = 1'b1;
				end
				CMD_REMOVE, CMD_LOOKUP: begin
					rsp_d.found = found;
					load        = 1'b1;
				end
				CMD_LIST: begin
					load = (count_q == '0);
				end
				default: begin
					load = 1'b1;
				end
			endcase
		end else if (list_go && (idx_q < count_q)) begin
			rsp_d.listed_address = slot[0];
			rsp_d.entry_valid    = 1'b1;
			rsp_d.last           = (idx_q == count_q - CW'(1));
			load                 = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			cmd_q  <= req.cmd;
			addr_q <= req.peer_address;
		end
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_go) begin
						idx_q <= '0;
						if (cmd_q == CMD_LIST && count_q != '0) begin
							state_q <= ST_LIST;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_LIST: begin
					if (list_go) begin
						idx_q <= idx_q + CW'(1);
						if (idx_q == CW'(MAX_BONDS - 1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
